// File: src/ple_pkg.sv
// shared types and codes for the positional list engine
package ple_pkg;

  // widths fixed by the interface fields
  localparam int CNT_W = 7;
  localparam int POS_W = 8;
  localparam int EXT_W = POS_W + 1;

  // operation codes
  localparam logic [2:0] FN_INS_FIRST = 3'd0;
  localparam logic [2:0] FN_INS_LAST  = 3'd1;
  localparam logic [2:0] FN_INS_POS   = 3'd2;
  localparam logic [2:0] FN_DEL_FIRST = 3'd3;
  localparam logic [2:0] FN_DEL_LAST  = 3'd4;
  localparam logic [2:0] FN_DEL_POS   = 3'd5;
  localparam logic [2:0] FN_DISPLAY   = 3'd6;

  // result status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_BADPOS = 2'd1;
  localparam logic [1:0] ST_EMPTY  = 2'd2;
  localparam logic [1:0] ST_FULL   = 2'd3;

  // cell operation codes
  localparam logic [1:0] MODE_HOLD = 2'd0;
  localparam logic [1:0] MODE_INS  = 2'd1;
  localparam logic [1:0] MODE_DEL  = 2'd2;
  localparam logic [1:0] MODE_ROT  = 2'd3;

  // command broadcast from the controller to every cell
  typedef struct packed {
    logic [1:0]       mode;
    logic [CNT_W-1:0] pos;
    logic [CNT_W-1:0] tail;
  } ple_cmd_t;

endpackage

// File: src/ple_cell.sv
// one storage cell of the list chain
module ple_cell #(
  parameter int DATA_WIDTH = 32,
  parameter int INDEX      = 0
) (
  input  logic                  clk,
  input  ple_pkg::ple_cmd_t     cmd,
  input  logic [DATA_WIDTH-1:0] ins_data,
  input  logic [DATA_WIDTH-1:0] left_data,
  input  logic [DATA_WIDTH-1:0] right_data,
  input  logic [DATA_WIDTH-1:0] head_data,
  output logic [DATA_WIDTH-1:0] data_q
);
  import ple_pkg::*;

  localparam logic [CNT_W-1:0] IDX_C = CNT_W'(INDEX);

  logic [DATA_WIDTH-1:0] data_r, data_nxt;

  // insert shifts toward the tail, delete and rotate shift toward the head
  always_comb begin
    data_nxt = data_r;
    case (cmd.mode)
      MODE_INS: begin
        if (IDX_C > cmd.pos) begin
          data_nxt = left_data;
        end else if (IDX_C == cmd.pos) begin
          data_nxt = ins_data;
        end
      end
      MODE_DEL: begin
        if (IDX_C >= cmd.pos) begin
          data_nxt = right_data;
        end
      end
      MODE_ROT: begin
        if (IDX_C == cmd.tail) begin
          data_nxt = head_data;
        end else if (IDX_C < cmd.tail) begin
          data_nxt = right_data;
        end
      end
      default: begin
        data_nxt = data_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_q = data_r;

endmodule

// File: src/ple_ctrl.sv
// operation decode, element count and display sequencing
module ple_ctrl #(
  parameter int CAPACITY   = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [2:0]            in_func,
  input  logic [7:0]            in_position,
  input  logic [DATA_WIDTH-1:0] head_data,
  output ple_pkg::ple_cmd_t     cmd,
  output logic                  out_valid,
  output logic [1:0]            out_status,
  output logic [31:0]           out_element,
  output logic [6:0]            out_element_index,
  output logic [6:0]            out_length,
  output logic                  out_last
);
  import ple_pkg::*;

  localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

  logic             busy_r, busy_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] disp_r, disp_nxt;
  logic             valid_r, valid_nxt;
  logic [1:0]       status_r, status_nxt;
  logic [31:0]      elem_r, elem_nxt;
  logic [6:0]       idx_r, idx_nxt;
  logic [6:0]       len_r;
  logic             last_r, last_nxt;

  logic [EXT_W-1:0] cnt_ext;
  logic [EXT_W-1:0] ins_pos1;
  logic [EXT_W-1:0] del_pos1;
  logic [CNT_W-1:0] disp_inc;

  assign cnt_ext  = {{(EXT_W-CNT_W){1'b0}}, count_r};
  assign disp_inc = disp_r + CNT_W'(1);

  // one-based target position for each operation family
  always_comb begin
    case (in_func)
      FN_INS_FIRST: ins_pos1 = EXT_W'(1);
      FN_INS_LAST:  ins_pos1 = cnt_ext + EXT_W'(1);
      default:      ins_pos1 = {1'b0, in_position};
    endcase
    case (in_func)
      FN_DEL_FIRST: del_pos1 = EXT_W'(1);
      FN_DEL_LAST:  del_pos1 = cnt_ext;
      default:      del_pos1 = {1'b0, in_position};
    endcase
  end

  // decode and sequencing
  always_comb begin
    cmd.mode   = MODE_HOLD;
    cmd.pos    = '0;
    cmd.tail   = count_r - CNT_W'(1);
    count_nxt  = count_r;
    busy_nxt   = busy_r;
    disp_nxt   = disp_r;
    valid_nxt  = 1'b0;
    status_nxt = ST_OK;
    elem_nxt   = '0;
    idx_nxt    = '0;
    last_nxt   = 1'b1;
    if (busy_r) begin
      // display: emit the head and rotate the occupied cells by one
      cmd.mode  = MODE_ROT;
      valid_nxt = 1'b1;
      elem_nxt  = 32'(head_data);
      idx_nxt   = disp_inc;
      last_nxt  = (disp_inc == count_r);
      disp_nxt  = disp_inc;
      if (disp_inc == count_r) begin
        busy_nxt = 1'b0;
      end
    end else if (start) begin
      valid_nxt = 1'b1;
      case (in_func)
        FN_INS_FIRST, FN_INS_LAST, FN_INS_POS: begin
          if (ins_pos1 == '0 || ins_pos1 > cnt_ext + EXT_W'(1)) begin
            status_nxt = ST_BADPOS;
          end else if (count_r == CAP_C) begin
            status_nxt = ST_FULL;
          end else begin
            cmd.mode  = MODE_INS;
            cmd.pos   = CNT_W'(ins_pos1 - EXT_W'(1));
            count_nxt = count_r + CNT_W'(1);
          end
        end
        FN_DEL_FIRST, FN_DEL_LAST, FN_DEL_POS: begin
          if (in_func != FN_DEL_POS && count_r == '0) begin
            status_nxt = ST_EMPTY;
          end else if (del_pos1 == '0 || del_pos1 > cnt_ext) begin
            status_nxt = ST_BADPOS;
          end else begin
            cmd.mode  = MODE_DEL;
            cmd.pos   = CNT_W'(del_pos1 - EXT_W'(1));
            count_nxt = count_r - CNT_W'(1);
          end
        end
        FN_DISPLAY: begin
          if (count_r == '0) begin
            status_nxt = ST_EMPTY;
          end else begin
            valid_nxt = 1'b0;
            busy_nxt  = 1'b1;
            disp_nxt  = '0;
          end
        end
        default: begin
          status_nxt = ST_OK;
        end
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      count_r <= '0;
      disp_r  <= '0;
      valid_r <= 1'b0;
    end else begin
      busy_r  <= busy_nxt;
      count_r <= count_nxt;
      disp_r  <= disp_nxt;
      valid_r <= valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    elem_r   <= elem_nxt;
    idx_r    <= idx_nxt;
    len_r    <= count_nxt;
    last_r   <= last_nxt;
  end

  assign busy              = busy_r;
  assign out_valid         = valid_r;
  assign out_status        = status_r;
  assign out_element       = elem_r;
  assign out_element_index = idx_r;
  assign out_length        = len_r;
  assign out_last          = last_r;

endmodule

// File: src/positional_list_engine.sv
// top level of the positional list engine: controller plus chain of cells
//
//  port group   direction  transfer when
//  in_*         input      start high and busy low at a rising edge
//  out_*        output     out_valid high, taken at the edge that ends the cycle
//
// Inserts, deletes and the unused code leave busy low; the next operation may
// start in the following cycle. The registered result shows in the next cycle.
// Display holds busy while it emits one result per element, as the occupied cells
// rotate one place per cycle toward the head; an empty list gives one result.
// Synchronous active-low reset empties the list; cell contents are not cleared.
// The receiver cannot stall; every result is shown for exactly one cycle.
module positional_list_engine #(
  parameter int CAPACITY   = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_func,
  input  logic [31:0] in_value,
  input  logic [7:0]  in_position,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [31:0] out_element,
  output logic [6:0]  out_element_index,
  output logic [6:0]  out_length,
  output logic        out_last
);
  import ple_pkg::*;

  ple_cmd_t              cmd;
  logic [DATA_WIDTH-1:0] ins_data;
  logic [DATA_WIDTH-1:0] cell_q [CAPACITY];

  assign ins_data = DATA_WIDTH'(in_value);

  // decode and sequencing
  ple_ctrl #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_func           (in_func),
    .in_position       (in_position),
    .head_data         (cell_q[0]),
    .cmd               (cmd),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_element       (out_element),
    .out_element_index (out_element_index),
    .out_length        (out_length),
    .out_last          (out_last)
  );

  // chain of cells, each linked to both neighbors
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_d, right_d;

    if (i == 0) begin : g_first
      assign left_d = cell_q[i];
    end else begin : g_mid_l
      assign left_d = cell_q[i-1];
    end

    if (i == CAPACITY - 1) begin : g_end
      assign right_d = cell_q[i];
    end else begin : g_mid_r
      assign right_d = cell_q[i+1];
    end

    ple_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .INDEX      (i)
    ) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .ins_data   (ins_data),
      .left_data  (left_d),
      .right_data (right_d),
      .head_data  (cell_q[0]),
      .data_q     (cell_q[i])
    );
  end

endmodule
